[hdl/esld_pkg.sv]
// Shared types, constants, name table and helper functions for the string literal decoder.
package esld_pkg;

    // Sizes
    localparam int MAX_LENGTH = 255;
    localparam int NAME_MAX   = 9;
    localparam int NAME_COUNT = 42;
    localparam int TABLE_SIZE = 42;
    localparam int NAME_LEN_W = $clog2(NAME_MAX + 2);
    localparam int NAME_IDX_W = $clog2(NAME_MAX);
    localparam int CNT_W      = 9;
    localparam int ROWS_MAX   = 3;

    // Character codes
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CODE_EOL  = 8'h9B;
    localparam logic [7:0] INV_MASK  = 8'h80;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_BAD_NAME  = 3'd2;
    localparam logic [2:0] ST_TOO_MANY  = 3'd3;
    localparam logic [2:0] ST_BAD_ESC   = 3'd4;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_COUNT  = 3'd1,
        M_NAME   = 3'd2,
        M_ESC    = 3'd3,
        M_HEX2   = 3'd4,
        M_CR     = 3'd5
    } mode_t;

    // One result row
    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] repeat_res;
        logic       is_status;
        logic [2:0] status;
        logic [7:0] final_length;
        logic       last;
    } row_t;

    // Rows produced by one request, lowest index first
    typedef struct packed {
        logic [1:0]              n;
        row_t [ROWS_MAX-1:0]     rows;
    } push_t;

    // Name table: text right-aligned, first character in the highest used byte
    localparam logic [8*NAME_MAX-1:0] GLYPH_TXT [TABLE_SIZE] = '{
        "heart", "rbranch", "rline", "tlcorner", "lbranch", "blcorner", "udiag",
        "ddiag", "rtriangle", "brblock", "ltriangle", "trblock", "tlblock",
        "tline", "bline", "blblock", "clubs", "brcorner", "hline", "cross",
        "ball", "bbar", "lline", "bbranch", "tbranch", "lbar", "trcorner",
        "esc", "up", "down", "left", "right", "diamond", "spade", "vline",
        "clr", "del", "ins", "tbar", "rbar", "eol", "bell"
    };

    localparam int GLYPH_LEN [TABLE_SIZE] = '{
        5, 7, 5, 8, 7, 8, 5, 5, 9, 7, 9, 7, 7, 5, 5, 7, 5, 8, 5, 5, 4,
        4, 5, 7, 7, 4, 8, 3, 2, 4, 4, 5, 7, 5, 5, 3, 3, 3, 4, 4, 3, 4
    };

    localparam logic [7:0] GLYPH_CODE [TABLE_SIZE] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10,
        8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20,
        8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30,
        8'd31, 8'd96, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd149, 8'd153,
        8'd155, 8'd253
    };

    // Match the collected name against every table entry in parallel; first hit wins
    function automatic logic [8:0] name_lookup(
        input logic [8*NAME_MAX-1:0] name_bytes,
        input logic [NAME_LEN_W-1:0] name_len
    );
        logic [8:0] res;
        logic       eq;
        logic [7:0] ref_byte;
        int         sh;
        res = '0;
        for (int j = TABLE_SIZE - 1; j >= 0; j--) begin
            eq = (j < NAME_COUNT) && (int'(name_len) == GLYPH_LEN[j]);
            for (int i = 0; i < NAME_MAX; i++) begin
                if (i < GLYPH_LEN[j]) begin
                    sh       = GLYPH_LEN[j] - 1 - i;
                    ref_byte = 8'(GLYPH_TXT[j] >> (8 * sh));
                    if (name_bytes[8*i +: 8] != ref_byte) begin
                        eq = 1'b0;
                    end
                end
            end
            if (eq) begin
                res = {1'b1, GLYPH_CODE[j]};
            end
        end
        return res;
    endfunction

    // Hex digit: bit 4 set when valid, low nibble the value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    // True when a run of rep more bytes still fits
    function automatic logic emit_fits(input logic [CNT_W-1:0] oc, input logic [7:0] rep);
        return ({1'b0, oc} + {2'b0, rep}) <= 10'(MAX_LENGTH);
    endfunction

    // Advance the output count, saturating one past the limit
    function automatic logic [CNT_W-1:0] count_add(
        input logic [CNT_W-1:0] oc,
        input logic [7:0]       rep
    );
        logic [CNT_W:0] s;
        s = {1'b0, oc} + {2'b0, rep};
        return (s > 10'(MAX_LENGTH + 1)) ? CNT_W'(MAX_LENGTH + 1) : s[CNT_W-1:0];
    endfunction

endpackage

[hdl/extended_string_literal_decoder_top.sv]
// Top level of the extended string literal decoder.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid / tready         tdata char_byte, tuser has_char, tlast end_of_string
//  m_axis    out  tvalid / tready         tdata out_byte..final_length, tuser is_status,
//                                         tlast last
//
// Each request is decoded in the cycle it is taken; its rows (up to three) land in a
// four-entry row queue that drains one row per cycle while m_axis_tready is high, so
// the output register of the queue parts the two sides.
// A request is taken whenever the queue holds at most one row: with m_axis_tready
// high, a steady stream of one row per request runs at one request per cycle; a
// request giving two or three rows holds off the next until the queue is back to one row.
// Reset clears the decoder state and empties the queue; no clearing pass is needed.
module extended_string_literal_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tuser,   // [0] has_char
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [15:8] repeat_res,
                                        // [18:16] status, [26:19] final_length, zero above
    output logic        m_axis_tuser,   // [0] is_status
    output logic        m_axis_tlast    // last
);

    esld_pkg::push_t  push;
    esld_pkg::row_t   row;
    logic             room;
    logic             fire;

    assign s_axis_tready = room;
    assign fire          = s_axis_tvalid && room;

    // Decode requests
    esld_decoder u_decoder (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .char_byte     (s_axis_tdata),
        .has_char      (s_axis_tuser),
        .end_of_string (s_axis_tlast),
        .push          (push)
    );

    // Queue result rows
    esld_row_fifo u_row_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_row   (row)
    );

    // Pack the output row
    assign m_axis_tdata = {5'b0, row.final_length, row.status, row.repeat_res, row.out_byte};
    assign m_axis_tuser = row.is_status;
    assign m_axis_tlast = row.last;

endmodule

[hdl/esld_decoder.sv]
// Decoder state and single-pass decode of one request into up to three result rows.
module esld_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          char_byte,
    input  logic                has_char,
    input  logic                end_of_string,
    output esld_pkg::push_t     push
);

    esld_pkg::mode_t                  mode_reg, mode_next;
    logic                             inv_reg, inv_next;
    logic [8:0]                       rc_reg, rc_next;
    logic [3:0]                       hh_reg, hh_next;
    logic [esld_pkg::NAME_LEN_W-1:0]  nl_reg, nl_next;
    logic [esld_pkg::CNT_W-1:0]       oc_reg, oc_next;
    logic [2:0]                       err_reg, err_next;
    logic [7:0]                       name_buf_reg [esld_pkg::NAME_MAX];

    logic                             buf_we;
    logic [esld_pkg::NAME_IDX_W-1:0]  buf_idx;
    logic [8*esld_pkg::NAME_MAX-1:0]  name_flat;
    logic [8:0]                       lookup;
    logic [4:0]                       hex;
    logic [7:0]                       invb;
    logic                             e_go;
    logic [7:0]                       e_byte;
    logic [7:0]                       e_rep;
    logic                             skip;
    logic [8:0]                       grp_rep;
    logic [12:0]                      rc_mul;
    logic [1:0]                       n;
    esld_pkg::row_t [esld_pkg::ROWS_MAX-1:0] rows;

    // Flatten the name buffer for the table match
    always_comb
    begin
        for (int i = 0; i < esld_pkg::NAME_MAX; i++) begin
            name_flat[8*i +: 8] = name_buf_reg[i];
        end
    end

    assign lookup  = esld_pkg::name_lookup(name_flat, nl_reg);
    assign hex     = esld_pkg::hex_digit(char_byte);
    assign invb    = inv_reg ? esld_pkg::INV_MASK : 8'h00;
    assign grp_rep = (rc_reg == 9'd0) ? 9'd1 : rc_reg;
    assign rc_mul  = {4'b0, rc_reg} * 13'd10 + {5'b0, 4'(char_byte - 8'h30)};

    // Decode one request
    always_comb
    begin
        mode_next = mode_reg;
        inv_next  = inv_reg;
        rc_next   = rc_reg;
        hh_next   = hh_reg;
        nl_next   = nl_reg;
        oc_next   = oc_reg;
        err_next  = err_reg;
        buf_we    = 1'b0;
        buf_idx   = nl_reg[esld_pkg::NAME_IDX_W-1:0];
        e_go      = 1'b0;
        e_byte    = 8'h00;
        e_rep     = 8'd1;
        skip      = 1'b0;
        n         = 2'd0;
        rows      = '0;

        if (fire && has_char && err_reg == 3'd0
            && oc_reg <= esld_pkg::CNT_W'(esld_pkg::MAX_LENGTH)) begin
            // Flush a pending CR unless it pairs with LF
            if (mode_reg == esld_pkg::M_CR) begin
                mode_next = esld_pkg::M_NORMAL;
                if (char_byte != esld_pkg::CH_LF) begin
                    if (esld_pkg::emit_fits(oc_next, 8'd1)) begin
                        rows[n].out_byte   = esld_pkg::CH_CR ^ invb;
                        rows[n].repeat_res = 8'd1;
                        n = n + 2'd1;
                    end
                    oc_next = esld_pkg::count_add(oc_next, 8'd1);
                    if (oc_next > esld_pkg::CNT_W'(esld_pkg::MAX_LENGTH)) begin
                        skip = 1'b1;
                    end
                end
            end

            if (!skip) begin
                case (mode_next)
                    esld_pkg::M_NORMAL:
                    begin
                        if (char_byte == esld_pkg::CH_LBRACE) begin
                            mode_next = esld_pkg::M_COUNT;
                            rc_next   = 9'd0;
                            nl_next   = '0;
                        end
                        else if (char_byte == esld_pkg::CH_TILDE) begin
                            inv_next = ~inv_reg;
                        end
                        else if (char_byte == esld_pkg::CH_BSLASH) begin
                            mode_next = esld_pkg::M_ESC;
                        end
                        else if (char_byte == esld_pkg::CH_CR) begin
                            mode_next = esld_pkg::M_CR;
                        end
                        else if (char_byte == esld_pkg::CH_LF) begin
                            e_go   = 1'b1;
                            e_byte = esld_pkg::CODE_EOL;
                        end
                        else begin
                            e_go   = 1'b1;
                            e_byte = char_byte ^ invb;
                        end
                    end
                    esld_pkg::M_COUNT:
                    begin
                        if (char_byte >= 8'h30 && char_byte <= 8'h39) begin
                            rc_next = (rc_mul > 13'd256) ? 9'd256 : rc_mul[8:0];
                        end
                        else begin
                            mode_next = esld_pkg::M_NAME;
                            nl_next   = '0;
                            if (char_byte != esld_pkg::CH_STAR) begin
                                buf_we  = 1'b1;
                                buf_idx = '0;
                                nl_next = esld_pkg::NAME_LEN_W'(1);
                            end
                        end
                    end
                    esld_pkg::M_NAME:
                    begin
                        if (char_byte == esld_pkg::CH_RBRACE) begin
                            // Resolve the group
                            if (!lookup[8]) begin
                                err_next = esld_pkg::ST_BAD_NAME;
                            end
                            else if (grp_rep > 9'(esld_pkg::MAX_LENGTH)
                                     || ({1'b0, grp_rep} + {1'b0, oc_next})
                                        > 10'(esld_pkg::MAX_LENGTH)) begin
                                err_next = esld_pkg::ST_TOO_MANY;
                            end
                            else begin
                                e_go      = 1'b1;
                                e_byte    = lookup[7:0] ^ invb;
                                e_rep     = grp_rep[7:0];
                                rc_next   = 9'd0;
                                mode_next = esld_pkg::M_NORMAL;
                            end
                        end
                        else if (nl_reg < esld_pkg::NAME_LEN_W'(esld_pkg::NAME_MAX)) begin
                            buf_we  = 1'b1;
                            nl_next = nl_reg + esld_pkg::NAME_LEN_W'(1);
                        end
                        else begin
                            nl_next = esld_pkg::NAME_LEN_W'(esld_pkg::NAME_MAX + 1);
                        end
                    end
                    esld_pkg::M_ESC:
                    begin
                        if (hex[4]) begin
                            hh_next   = hex[3:0];
                            mode_next = esld_pkg::M_HEX2;
                        end
                        else begin
                            e_go      = 1'b1;
                            e_byte    = char_byte ^ invb;
                            mode_next = esld_pkg::M_NORMAL;
                        end
                    end
                    esld_pkg::M_HEX2:
                    begin
                        if (hex[4]) begin
                            e_go      = 1'b1;
                            e_byte    = {hh_reg, hex[3:0]};
                            mode_next = esld_pkg::M_NORMAL;
                        end
                        else begin
                            err_next = esld_pkg::ST_BAD_ESC;
                        end
                    end
                    default:
                    begin
                        mode_next = esld_pkg::M_NORMAL;
                    end
                endcase

                // Emit the decoded run if it fits
                if (e_go) begin
                    if (esld_pkg::emit_fits(oc_next, e_rep)) begin
                        rows[n].out_byte   = e_byte;
                        rows[n].repeat_res = e_rep;
                        n = n + 2'd1;
                    end
                    oc_next = esld_pkg::count_add(oc_next, e_rep);
                end
            end
        end

        // Status row closes the literal and restores the reset state
        if (fire && end_of_string) begin
            rows[n].is_status = 1'b1;
            rows[n].last      = 1'b1;
            if (err_next != 3'd0) begin
                rows[n].status = err_next;
            end
            else if (oc_next > esld_pkg::CNT_W'(esld_pkg::MAX_LENGTH)) begin
                rows[n].status       = esld_pkg::ST_TRUNC;
                rows[n].final_length = 8'(esld_pkg::MAX_LENGTH);
            end
            else begin
                rows[n].status       = esld_pkg::ST_OK;
                rows[n].final_length = oc_next[7:0];
            end
            n = n + 2'd1;
            mode_next = esld_pkg::M_NORMAL;
            inv_next  = 1'b0;
            rc_next   = 9'd0;
            hh_next   = 4'd0;
            nl_next   = '0;
            oc_next   = '0;
            err_next  = 3'd0;
        end
    end

    assign push.n    = n;
    assign push.rows = rows;

    // Hold decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= esld_pkg::M_NORMAL;
            inv_reg  <= 1'b0;
            rc_reg   <= 9'd0;
            hh_reg   <= 4'd0;
            nl_reg   <= '0;
            oc_reg   <= '0;
            err_reg  <= 3'd0;
        end
        else begin
            mode_reg <= mode_next;
            inv_reg  <= inv_next;
            rc_reg   <= rc_next;
            hh_reg   <= hh_next;
            nl_reg   <= nl_next;
            oc_reg   <= oc_next;
            err_reg  <= err_next;
        end
    end

    // Store name characters
    always_ff @(posedge clk)
    begin
        if (buf_we) begin
            name_buf_reg[buf_idx] <= char_byte;
        end
    end

endmodule

[hdl/esld_row_fifo.sv]
// Four-entry result row queue: takes up to three rows per cycle, gives one while out_ready is high.
module esld_row_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  esld_pkg::push_t  push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output esld_pkg::row_t   out_row
);

    localparam int DEPTH = 4;

    esld_pkg::row_t  mem_reg [DEPTH];
    logic [1:0]      wr_ptr_reg, wr_ptr_next;
    logic [1:0]      rd_ptr_reg, rd_ptr_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_row   = mem_reg[rd_ptr_reg];
    assign room      = (cnt_reg <= 3'(DEPTH - esld_pkg::ROWS_MAX));

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        cnt_next    = cnt_reg + {1'b0, push.n} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write new rows in order after the tail
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < DEPTH; e++) begin
            for (int k = 0; k < esld_pkg::ROWS_MAX; k++) begin
                if (2'(k) < push.n && 2'(wr_ptr_reg + 2'(k)) == 2'(e)) begin
                    mem_reg[e] <= push.rows[k];
                end
            end
        end
    end

endmodule
